// ----- rtl/mlj_pkg.sv -----
// shared types, constants and functions for the mlp jacobian row unit
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package mlj_pkg;

    localparam int NUM_INPUTS_DEF   = 4;
    localparam int NUM_HIDDEN_DEF   = 8;
    localparam int SIG_TABLE_DEF    = 256;
    localparam int FIFO_DEPTH       = 4;
    localparam int Q_ONE            = 65536;
    localparam int ACC_W            = 52;

    typedef enum logic [1:0] {
        FUNC_HW_WRITE = 2'd0,
        FUNC_OW_WRITE = 2'd1,
        FUNC_X_WRITE  = 2'd2,
        FUNC_COMPUTE  = 2'd3
    } func_t;

    typedef struct packed {
        func_t              op;
        logic               in_range;
        logic [5:0]         slot;
        logic signed [31:0] value;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMUL,
        ST_HACC,
        ST_SIG,
        ST_SIGW,
        ST_OMUL,
        ST_OACC,
        ST_RES,
        ST_HSQM,
        ST_HSQ,
        ST_EPRED,
        ST_EACT,
        ST_GMUL,
        ST_PMUL,
        ST_JMUL,
        ST_EJAC
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sh0_0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -68'sh0_0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // shift and subtract long division, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], a[k]};
            if (r >= b)
            begin
                r = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // table entry i of n over [-8,8), evaluated at elaboration only
    function automatic logic [16:0] sig_entry(input int i, input int n);
        longint signed   xq;
        longint unsigned ax;
        longint unsigned term;
        longint unsigned s;
        longint unsigned d;
        longint unsigned num;
        xq = -64'sd524288 + longint'(udiv64(64'(i) << 20, 64'(n)));
        ax = (xq < 0) ? longint'(-xq) : longint'(xq);
        term = 64'd1 << 32;
        s = term;
        for (int k = 1; k < 64; k++)
        begin
            term = udiv64(term * ax, 64'(k) * 64'(Q_ONE));
            s = s + term;
        end
        d = s + (64'd1 << 32);
        num = (xq >= 0) ? s * 64'd65536 : (64'd1 << 48);
        return 17'(udiv64(num + (d >> 1), d));
    endfunction

endpackage

// ----- rtl/mlj_front.sv -----
// front stage: takes input requests, decodes and range-checks them
// feeds the request queue; depends on mlj_pkg
`timescale 1ns / 1ps

module mlj_front #(
    parameter int NUM_INPUTS = mlj_pkg::NUM_INPUTS_DEF,
    parameter int NUM_HIDDEN = mlj_pkg::NUM_HIDDEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [5:0]          slot,
    input  logic signed [31:0]  operand_value,
    input  logic                q_full,
    output logic                q_push,
    output mlj_pkg::item_t      q_item
);
    import mlj_pkg::*;

    localparam int HW_COUNT = NUM_HIDDEN * NUM_INPUTS;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = valid_reg && !q_full;
    assign q_item   = item_reg;

    always_comb
    begin
        item_next.op    = func_t'(func);
        item_next.slot  = slot;
        item_next.value = operand_value;
        case (func_t'(func))
            FUNC_HW_WRITE: item_next.in_range = (32'(slot) < 32'(HW_COUNT));
            FUNC_OW_WRITE: item_next.in_range = (32'(slot) <= 32'(NUM_HIDDEN));
            FUNC_X_WRITE:  item_next.in_range = (32'(slot) < 32'(NUM_INPUTS));
            FUNC_COMPUTE:  item_next.in_range = 1'b1;
            default:       item_next.in_range = 1'b0;
        endcase
        valid_next = accept || (valid_reg && !q_push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

// ----- rtl/mlj_queue.sv -----
// short request queue between front and back stages
// depends on mlj_pkg
`timescale 1ns / 1ps

module mlj_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mlj_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output mlj_pkg::item_t  pop_item
);
    import mlj_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t         mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full     = (count_reg == (PW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/mlj_back.sv -----
// back stage: weight and input stores, shared multiplier, sigmoid rom
// and the sequencer that emits prediction and jacobian row; depends on mlj_pkg
`timescale 1ns / 1ps

module mlj_back #(
    parameter int NUM_INPUTS         = mlj_pkg::NUM_INPUTS_DEF,
    parameter int NUM_HIDDEN         = mlj_pkg::NUM_HIDDEN_DEF,
    parameter int SIGMOID_TABLE_SIZE = mlj_pkg::SIG_TABLE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  mlj_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [5:0]          position,
    output logic signed [31:0]  result_value,
    output logic signed [31:0]  residual,
    output logic [30:0]         half_sq_error,
    output logic                last
);
    import mlj_pkg::*;

    localparam int HW_COUNT = NUM_HIDDEN * NUM_INPUTS;
    localparam int HW_AW    = (HW_COUNT > 1) ? $clog2(HW_COUNT) : 1;
    localparam int OW_AW    = $clog2(NUM_HIDDEN + 1);
    localparam int A_AW     = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int I_AW     = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int COLS     = NUM_HIDDEN + 1 + HW_COUNT;
    localparam int COL_W    = $clog2(COLS + 1);
    localparam int T_AW     = $clog2(SIGMOID_TABLE_SIZE);
    localparam int T_PW     = 20 + $clog2(SIGMOID_TABLE_SIZE + 1);

    logic signed [31:0] hw_mem [HW_COUNT];
    logic signed [31:0] ow_mem [NUM_HIDDEN + 1];
    logic signed [31:0] x_mem  [NUM_INPUTS];
    logic signed [31:0] act_mem [NUM_HIDDEN];
    logic [16:0]        sig_tab [SIGMOID_TABLE_SIZE];

    for (genvar g = 0; g < SIGMOID_TABLE_SIZE; g++)
    begin : g_tab
        localparam logic [16:0] ENTRY = sig_entry(g, SIGMOID_TABLE_SIZE);
        assign sig_tab[g] = ENTRY;
    end

    state_t                 state_reg;
    state_t                 state_next;
    logic [OW_AW-1:0]       h_reg;
    logic [I_AW-1:0]        i_reg;
    logic [HW_AW-1:0]       hw_idx_reg;
    logic [COL_W-1:0]       col_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [65:0]     prod_reg;
    logic signed [32:0]     p_reg;
    logic signed [31:0]     target_reg;
    logic signed [31:0]     y_reg;
    logic signed [31:0]     res_reg;
    logic [30:0]            hsq_reg;
    logic [16:0]            sig_reg;
    logic                   under_reg;
    logic                   over_reg;

    logic                   out_valid_reg;
    logic                   kind_reg;
    logic [5:0]             pos_reg;
    logic signed [31:0]     val_reg;
    logic signed [31:0]     res_out_reg;
    logic [30:0]            hsq_out_reg;
    logic                   last_reg;

    logic                   ofree;
    logic                   emit;
    logic                   emit_last;
    logic signed [31:0]     emit_val;
    logic                   emit_kind;
    logic signed [32:0]     mul_a;
    logic signed [32:0]     mul_b;
    logic signed [65:0]     prod_sh;
    logic [A_AW-1:0]        ha;
    logic                   h_end;
    logic                   i_end;
    logic signed [31:0]     hsum;
    logic [19:0]            t_off;
    logic [T_PW-1:0]        t_prod;
    logic [T_AW-1:0]        t_idx;
    logic signed [31:0]     y_sat;
    logic signed [31:0]     res_sat;
    logic signed [32:0]     mag;
    logic [16:0]            act_new;

    assign ha      = h_reg[A_AW-1:0];
    assign h_end   = (h_reg == OW_AW'(NUM_HIDDEN - 1));
    assign i_end   = (i_reg == I_AW'(NUM_INPUTS - 1));
    assign prod_sh = prod_reg >>> 16;
    assign ofree   = !out_valid_reg || !out_stall;

    assign hsum    = sat32(68'(acc_reg));
    assign t_off   = 20'(33'(hsum) + 33'sd524288);
    assign t_prod  = T_PW'(t_off) * T_PW'(SIGMOID_TABLE_SIZE);
    assign t_idx   = t_prod[20 +: T_AW];
    assign y_sat   = sat32(68'(acc_reg));
    assign res_sat = sat32(68'(target_reg) - 68'(y_sat));
    assign mag     = (res_reg < 0) ? -33'(res_reg) : 33'(res_reg);
    assign act_new = under_reg ? 17'd0 : (over_reg ? 17'(Q_ONE) : sig_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HMUL:
            begin
                mul_a = 33'(hw_mem[hw_idx_reg]);
                mul_b = 33'(x_mem[i_reg]);
            end
            ST_OMUL:
            begin
                mul_a = 33'(ow_mem[h_reg]);
                mul_b = 33'(act_mem[ha]);
            end
            ST_HSQM:
            begin
                mul_a = mag;
                mul_b = mag;
            end
            ST_GMUL:
            begin
                mul_a = 33'(act_mem[ha]);
                mul_b = 33'sd65536 - 33'(act_mem[ha]);
            end
            ST_PMUL:
            begin
                mul_a = 33'(ow_mem[h_reg]);
                mul_b = prod_sh[32:0];
            end
            ST_JMUL:
            begin
                mul_a = (i_reg == '0) ? prod_sh[32:0] : p_reg;
                mul_b = 33'(x_mem[i_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_kind  = 1'b1;
        emit_last  = 1'b0;
        emit_val   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == FUNC_COMPUTE)
                        state_next = ST_HMUL;
                end
            end
            ST_HMUL: state_next = ST_HACC;
            ST_HACC: state_next = i_end ? ST_SIG : ST_HMUL;
            ST_SIG:  state_next = ST_SIGW;
            ST_SIGW: state_next = h_end ? ST_OMUL : ST_HMUL;
            ST_OMUL: state_next = ST_OACC;
            ST_OACC: state_next = h_end ? ST_RES : ST_OMUL;
            ST_RES:  state_next = ST_HSQM;
            ST_HSQM: state_next = ST_HSQ;
            ST_HSQ:  state_next = ST_EPRED;
            ST_EPRED:
            begin
                emit_kind = 1'b0;
                emit_val  = y_reg;
                if (ofree)
                begin
                    emit       = 1'b1;
                    state_next = ST_EACT;
                end
            end
            ST_EACT:
            begin
                emit_val = (h_reg == OW_AW'(NUM_HIDDEN)) ? -32'sd65536 : -act_mem[ha];
                if (ofree)
                begin
                    emit = 1'b1;
                    if (h_reg == OW_AW'(NUM_HIDDEN))
                        state_next = ST_GMUL;
                end
            end
            ST_GMUL: state_next = ST_PMUL;
            ST_PMUL: state_next = ST_JMUL;
            ST_JMUL: state_next = ST_EJAC;
            ST_EJAC:
            begin
                emit_val  = sat32(-68'(prod_sh));
                emit_last = h_end && i_end;
                if (ofree)
                begin
                    emit = 1'b1;
                    if (emit_last)
                        state_next = ST_IDLE;
                    else if (i_end)
                        state_next = ST_GMUL;
                    else
                        state_next = ST_JMUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < HW_COUNT; k++)
                hw_mem[k] <= '0;
            for (int k = 0; k <= NUM_HIDDEN; k++)
                ow_mem[k] <= '0;
            for (int k = 0; k < NUM_INPUTS; k++)
                x_mem[k] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit || (out_valid_reg && out_stall);
            if (q_pop && q_item.in_range)
            begin
                case (q_item.op)
                    FUNC_HW_WRITE: hw_mem[q_item.slot[HW_AW-1:0]] <= q_item.value;
                    FUNC_OW_WRITE: ow_mem[q_item.slot[OW_AW-1:0]] <= q_item.value;
                    FUNC_X_WRITE:  x_mem[q_item.slot[I_AW-1:0]]   <= q_item.value;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // product held while a jacobian entry waits
        if (state_reg != ST_EJAC)
            prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                h_reg      <= '0;
                i_reg      <= '0;
                hw_idx_reg <= '0;
                acc_reg    <= '0;
                target_reg <= q_item.value;
            end
            ST_HACC:
            begin
                acc_reg    <= acc_reg + ACC_W'(prod_sh);
                hw_idx_reg <= hw_idx_reg + 1'b1;
                i_reg      <= i_end ? '0 : i_reg + 1'b1;
            end
            ST_SIG:
            begin
                sig_reg   <= sig_tab[t_idx];
                under_reg <= (hsum < -32'sd524288);
                over_reg  <= (hsum >= 32'sd524288);
            end
            ST_SIGW:
            begin
                act_mem[ha] <= 32'(act_new);
                if (h_end)
                begin
                    h_reg   <= '0;
                    acc_reg <= ACC_W'(ow_mem[OW_AW'(NUM_HIDDEN)]);
                end
                else
                begin
                    h_reg   <= h_reg + 1'b1;
                    acc_reg <= '0;
                end
            end
            ST_OACC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_sh);
                h_reg   <= h_end ? '0 : h_reg + 1'b1;
            end
            ST_RES:
            begin
                y_reg   <= y_sat;
                res_reg <= res_sat;
            end
            ST_HSQ:
            begin
                if (prod_reg[65:17] > 49'h7FFF_FFFF)
                    hsq_reg <= 31'h7FFF_FFFF;
                else
                    hsq_reg <= prod_reg[47:17];
                col_reg <= '0;
            end
            ST_EACT:
            begin
                if (emit)
                begin
                    col_reg <= col_reg + 1'b1;
                    h_reg   <= (h_reg == OW_AW'(NUM_HIDDEN)) ? '0 : h_reg + 1'b1;
                    i_reg   <= '0;
                end
            end
            ST_JMUL:
            begin
                if (i_reg == '0)
                    p_reg <= prod_sh[32:0];
            end
            ST_EJAC:
            begin
                if (emit)
                begin
                    col_reg <= col_reg + 1'b1;
                    if (i_end)
                    begin
                        i_reg <= '0;
                        h_reg <= h_reg + 1'b1;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            kind_reg    <= emit_kind;
            pos_reg     <= emit_kind ? 6'(col_reg) : 6'd0;
            val_reg     <= emit_val;
            res_out_reg <= res_reg;
            hsq_out_reg <= hsq_reg;
            last_reg    <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign position      = pos_reg;
    assign result_value  = val_reg;
    assign residual      = res_out_reg;
    assign half_sq_error = hsq_out_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_last_is_jac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> kind_reg)
        else $error("last flag on a prediction result");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped while a compute is running");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(val_reg))
        else $error("stalled result overwritten");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> 32'(col_reg) < 32'(COLS))
        else $error("jacobian column past end of row");
`endif

endmodule

// ----- rtl/mlp_lm_jacobian_row_unit.sv -----
// top level of the mlp jacobian row unit: front, request queue and back stage
// depends on mlj_pkg, mlj_front, mlj_queue, mlj_back
`timescale 1ns / 1ps

// In-range write requests (func 0..2) are applied in the back stage when
// popped from the queue. A compute request (func 3) runs on one shared 33x33
// multiplier, each multiply-accumulate passing through a multiply state and
// an accumulate state, and emits 2 + NUM_HIDDEN + NUM_HIDDEN*NUM_INPUTS
// results. The front and a four entry queue keep taking requests while the
// back stage computes.
module mlp_lm_jacobian_row_unit #(
    parameter int NUM_INPUTS         = mlj_pkg::NUM_INPUTS_DEF,
    parameter int NUM_HIDDEN         = mlj_pkg::NUM_HIDDEN_DEF,
    parameter int SIGMOID_TABLE_SIZE = mlj_pkg::SIG_TABLE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [5:0]          slot,
    input  logic signed [31:0]  operand_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [5:0]          position,
    output logic signed [31:0]  result_value,
    output logic signed [31:0]  residual,
    output logic [30:0]         half_sq_error,
    output logic                last
);
    import mlj_pkg::*;

    logic  q_full;
    logic  q_push;
    item_t q_in;
    logic  q_pop;
    logic  q_empty;
    item_t q_out;

    mlj_front #(
        .NUM_INPUTS (NUM_INPUTS),
        .NUM_HIDDEN (NUM_HIDDEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .slot          (slot),
        .operand_value (operand_value),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    mlj_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_out)
    );

    mlj_back #(
        .NUM_INPUTS         (NUM_INPUTS),
        .NUM_HIDDEN         (NUM_HIDDEN),
        .SIGMOID_TABLE_SIZE (SIGMOID_TABLE_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_out),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .position      (position),
        .result_value  (result_value),
        .residual      (residual),
        .half_sq_error (half_sq_error),
        .last          (last)
    );

endmodule
